// File: src/bqlp_pkg.sv
// Shared constants and types of the biquad low-pass filter.
`timescale 1ns / 1ps

package bqlp_pkg;

  // Fixed-point format of the coefficients.
  localparam int COEF_FRAC_BITS = 14;

  // Field and history widths.
  localparam int SAMPLE_W        = 9;
  localparam int IN_SCALE_SHIFT  = 5;   // inputs are scaled by 32
  localparam int OUT_SCALE_SHIFT = 5;   // outputs are divided by 32
  localparam int XH_W            = SAMPLE_W + IN_SCALE_SHIFT;
  localparam int YH_W            = 32;
  localparam int COEF_W          = 17;
  localparam int OUT_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = COEF_W;

  // Products and their exact sum.
  localparam int PX_W   = COEF_W + XH_W;
  localparam int PY_W   = COEF_W + YH_W;
  localparam int SUM_W  = PY_W + 3;
  localparam int YE_W   = YH_W + 1;

  // Bias values that turn an arithmetic shift into truncation toward zero.
  localparam logic [SUM_W-1:0] FRAC_BIAS = SUM_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
  localparam logic [YE_W-1:0]  OUT_BIAS  = YE_W'((64'd1 << OUT_SCALE_SHIFT) - 64'd1);

  // Saturation limits of the emitted sample.
  localparam logic signed [YE_W-1:0] SAT_MAX = YE_W'(32767);
  localparam logic signed [YE_W-1:0] SAT_MIN = -YE_W'(32768);

  // Reset coefficients: low-pass near 3 kHz at a 44.1 kHz sample rate.
  localparam logic signed [COEF_W-1:0] RST_A0 = COEF_W'(569);
  localparam logic signed [COEF_W-1:0] RST_A1 = COEF_W'(1139);
  localparam logic signed [COEF_W-1:0] RST_A2 = COEF_W'(569);
  localparam logic signed [COEF_W-1:0] RST_B1 = -COEF_W'(23060);
  localparam logic signed [COEF_W-1:0] RST_B2 = COEF_W'(8956);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A0 = 3'd0,
    CFG_COEF_A1 = 3'd1,
    CFG_COEF_A2 = 3'd2,
    CFG_COEF_B1 = 3'd3,
    CFG_COEF_B2 = 3'd4
  } cfg_idx_e;

endpackage

// File: src/bqlp_stream_if.sv
// Valid/ready stream interfaces for the filter's input and result channels.
`timescale 1ns / 1ps

interface bqlp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bqlp_pkg::SAMPLE_W-1:0] sample;
  logic                                clear_history;

  modport source (output valid, output sample, output clear_history, input ready);
  modport sink   (input valid, input sample, input clear_history, output ready);
endinterface

interface bqlp_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [bqlp_pkg::OUT_W-1:0] filtered_sample;

  modport source (output valid, output filtered_sample, input ready);
  modport sink   (input valid, input filtered_sample, output ready);
endinterface

// File: src/biquad_lowpass_filter.sv
// Top level of the second-order direct-form-I low-pass filter.
`timescale 1ns / 1ps

// The filter takes one 9-bit signed sample per transfer and returns exactly one
// 16-bit saturated result per sample, in order. A sample is first captured in an
// input register; from there the five coefficient products, their exact sum, the
// truncating divisions and the saturation are computed in one pass and written to
// the result register together with the updated history. While the result side
// does not stall, a new sample can be taken every cycle; that rate is set by the
// feedback path through the two 17x32 output-history multipliers, which runs
// combinationally from the history registers back into them. While a result
// waits, the input register still takes one more sample; the input stalls only
// once that register is full as well. Setting clear_history zeroes all history
// before that sample is filtered. The user must write the coefficients through
// the cfg port (index 0..4 = a0, a1, a2, b1, b2; other indexes are ignored) only
// while the filter is idle; the block itself does not enforce this. They reset
// to a Butterworth low-pass near 3 kHz at 44.1 kHz.
module biquad_lowpass_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bqlp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bqlp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  bqlp_in_if.sink                              in_i,
  bqlp_out_if.source                           out_o
);

  // Coefficient registers.
  logic signed [bqlp_pkg::COEF_W-1:0] a0_q, a1_q, a2_q, b1_q, b2_q;

  // Input register stage.
  logic                                 s1_valid_q;
  logic signed [bqlp_pkg::SAMPLE_W-1:0] s1_sample_q;
  logic                                 s1_clear_q;

  // Filter history.
  logic signed [bqlp_pkg::XH_W-1:0] xh0_q, xh1_q, xh0_d, xh1_d;
  logic signed [bqlp_pkg::YH_W-1:0] yh0_q, yh1_q, yh0_d, yh1_d;

  // Result register.
  logic                              out_valid_q;
  logic signed [bqlp_pkg::OUT_W-1:0] out_q, out_d;

  // Handshake control.
  logic out_load;
  logic s1_adv;
  logic in_xfer;

  // Datapath.
  logic signed [bqlp_pkg::XH_W-1:0]  x0;
  logic signed [bqlp_pkg::XH_W-1:0]  xh0_eff, xh1_eff;
  logic signed [bqlp_pkg::YH_W-1:0]  yh0_eff, yh1_eff;
  logic signed [bqlp_pkg::PX_W-1:0]  p_a0, p_a1, p_a2;
  logic signed [bqlp_pkg::PY_W-1:0]  p_b1, p_b2;
  logic signed [bqlp_pkg::SUM_W-1:0] sum, sum_biased, quot;
  logic signed [bqlp_pkg::YH_W-1:0]  y0;
  logic signed [bqlp_pkg::YE_W-1:0]  y0_ext, y0_biased, emit;

  // The result register loads when it is empty or its transfer completes this
  // cycle; the input register passes its sample on whenever that happens.
  assign out_load = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && out_load;
  assign in_i.ready = !s1_valid_q || out_load;
  assign in_xfer  = in_i.valid && in_i.ready;

  // Coefficient writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a0_q <= bqlp_pkg::RST_A0;
      a1_q <= bqlp_pkg::RST_A1;
      a2_q <= bqlp_pkg::RST_A2;
      b1_q <= bqlp_pkg::RST_B1;
      b2_q <= bqlp_pkg::RST_B2;
    end else if (cfg_we_i) begin
      case (bqlp_pkg::cfg_idx_e'(cfg_idx_i))
        bqlp_pkg::CFG_COEF_A0: a0_q <= $signed(cfg_data_i);
        bqlp_pkg::CFG_COEF_A1: a1_q <= $signed(cfg_data_i);
        bqlp_pkg::CFG_COEF_A2: a2_q <= $signed(cfg_data_i);
        bqlp_pkg::CFG_COEF_B1: b1_q <= $signed(cfg_data_i);
        bqlp_pkg::CFG_COEF_B2: b2_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Input register: valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Input register: payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_sample_q <= in_i.sample;
      s1_clear_q  <= in_i.clear_history;
    end
  end

  // A clear request makes this sample see an all-zero history.
  always_comb begin
    x0      = bqlp_pkg::XH_W'(s1_sample_q) <<< bqlp_pkg::IN_SCALE_SHIFT;
    xh0_eff = s1_clear_q ? '0 : xh0_q;
    xh1_eff = s1_clear_q ? '0 : xh1_q;
    yh0_eff = s1_clear_q ? '0 : yh0_q;
    yh1_eff = s1_clear_q ? '0 : yh1_q;
  end

  // Five parallel products and their exact sum.
  always_comb begin
    p_a0 = bqlp_pkg::PX_W'(a0_q) * bqlp_pkg::PX_W'(x0);
    p_a1 = bqlp_pkg::PX_W'(a1_q) * bqlp_pkg::PX_W'(xh0_eff);
    p_a2 = bqlp_pkg::PX_W'(a2_q) * bqlp_pkg::PX_W'(xh1_eff);
    p_b1 = bqlp_pkg::PY_W'(b1_q) * bqlp_pkg::PY_W'(yh0_eff);
    p_b2 = bqlp_pkg::PY_W'(b2_q) * bqlp_pkg::PY_W'(yh1_eff);
    sum  = bqlp_pkg::SUM_W'(p_a0) + bqlp_pkg::SUM_W'(p_a1) + bqlp_pkg::SUM_W'(p_a2)
         - bqlp_pkg::SUM_W'(p_b1) - bqlp_pkg::SUM_W'(p_b2);
  end

  // Divide by 2^COEF_FRAC_BITS and by 32, both truncating toward zero: a
  // negative value gets the divisor minus one added before the shift.
  always_comb begin
    sum_biased = sum + (sum[bqlp_pkg::SUM_W-1] ? $signed(bqlp_pkg::FRAC_BIAS) : '0);
    quot       = sum_biased >>> bqlp_pkg::COEF_FRAC_BITS;
    y0         = $signed(quot[bqlp_pkg::YH_W-1:0]);
    y0_ext     = bqlp_pkg::YE_W'(y0);
    y0_biased  = y0_ext + (y0[bqlp_pkg::YH_W-1] ? $signed(bqlp_pkg::OUT_BIAS) : '0);
    emit       = y0_biased >>> bqlp_pkg::OUT_SCALE_SHIFT;
    if (emit > bqlp_pkg::SAT_MAX) begin
      out_d = $signed(bqlp_pkg::SAT_MAX[bqlp_pkg::OUT_W-1:0]);
    end else if (emit < bqlp_pkg::SAT_MIN) begin
      out_d = $signed(bqlp_pkg::SAT_MIN[bqlp_pkg::OUT_W-1:0]);
    end else begin
      out_d = $signed(emit[bqlp_pkg::OUT_W-1:0]);
    end
  end

  // New history after this sample.
  always_comb begin
    xh0_d = x0;
    xh1_d = xh0_eff;
    yh0_d = y0;
    yh1_d = yh0_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh0_q <= '0;
      xh1_q <= '0;
      yh0_q <= '0;
      yh1_q <= '0;
    end else if (s1_adv) begin
      xh0_q <= xh0_d;
      xh1_q <= xh1_d;
      yh0_q <= yh0_d;
      yh1_q <= yh1_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_sample = out_q;

  // A sample that is filtered always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("filtered sample did not reach the result register");

  // A new sample entering a full input register requires the held one to move on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s1_valid_q) |-> s1_adv)
    else $error("input register overwritten before its sample was filtered");

  // After a clear, the older history slots hold zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_clear_q) |=> (xh1_q == '0 && yh1_q == '0))
    else $error("history not cleared");

  // Without a clear, history shifts by one slot per filtered sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_clear_q) |=> (xh1_q == $past(xh0_q) && yh1_q == $past(yh0_q)))
    else $error("history did not shift");

endmodule

// File: sim/tb_biquad_lowpass_filter.sv
// Self-checking testbench of the biquad low-pass filter.
`timescale 1ns / 1ps

// The filter is driven through its input stream with signed samples and the
// clear flag, and every result transfer on the output stream is compared with
// a cycle-free model of the direct-form-I recurrence that is kept in this
// module. The model is advanced once per accepted input transfer and its
// result is queued, so results are checked strictly in order.
//
// The run starts with a short directed table. Sample rows send one sample.
// Register rows write one coefficient once the filter has drained. Where a
// result is obvious, such as zero input after reset or after a history clear,
// or any input under a unity feed-forward gain, the table carries it and that
// value is checked instead of the model's. A random part follows. It is split
// into phases, and each phase loads a fresh coefficient set: the reset set,
// all-maximum, all-minimum, a mix of extremes, fully random, a small detuning
// of the reset set, or a pure feed-forward set. Writes to unused register
// indexes are mixed in and must have no effect. Unstable sets drive the output
// history into saturation and 32-bit wrap, which the model follows bit for
// bit.
//
// The sender works in bursts with random gaps. The receiver cycles through
// stall patterns of its own, including long stretches with no stall at all.
module tb_biquad_lowpass_filter;

  localparam int N_PHASES        = 16;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES    = 16;

  localparam int SAMPLE_MAX = 2**(bqlp_pkg::SAMPLE_W-1) - 1;
  localparam int SAMPLE_MIN = -(2**(bqlp_pkg::SAMPLE_W-1));
  localparam int OUT_MAX    = 2**(bqlp_pkg::OUT_W-1) - 1;
  localparam int OUT_MIN    = -(2**(bqlp_pkg::OUT_W-1));
  localparam int COEF_MAX   = 2**(bqlp_pkg::COEF_W-1) - 1;
  localparam int COEF_MIN   = -(2**(bqlp_pkg::COEF_W-1));
  localparam int COEF_UNITY = 2**bqlp_pkg::COEF_FRAC_BITS;

  // Register indexes past the last coefficient; writes to them are dropped.
  localparam logic [bqlp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO =
    bqlp_pkg::CFG_IDX_W'(bqlp_pkg::CFG_COEF_B2) + 1'b1;
  localparam logic [bqlp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = {bqlp_pkg::CFG_IDX_W{1'b1}};

  localparam logic signed [bqlp_pkg::COEF_W-1:0] RESET_COEFS [5] = '{
    bqlp_pkg::RST_A0, bqlp_pkg::RST_A1, bqlp_pkg::RST_A2,
    bqlp_pkg::RST_B1, bqlp_pkg::RST_B2};

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef enum int {
    SET_RESET, SET_MAX, SET_MIN, SET_MIXED, SET_RANDOM, SET_DETUNED, SET_FIR
  } coef_set_e;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_e;

  // One row of the directed table. For a sample row, value is the sample and
  // known/result optionally carry an obvious output. For a register row, value
  // is the data written to reg_idx.
  typedef struct {
    row_kind_e                      kind;
    logic [bqlp_pkg::CFG_IDX_W-1:0] reg_idx;
    int                             value;
    logic                           clear;
    logic                           known;
    int                             result;
  } dir_row_t;

  localparam int N_DIR_ROWS = 37;

  dir_row_t directed_rows [N_DIR_ROWS] = '{
    // Reset coefficients, empty history: silence in, silence out.
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, 0,          1'b0, 1'b1, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MAX, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MAX, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MIN, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MIN, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, 1,          1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, -1,         1'b0, 1'b0, 0},
    // A clear wipes the history, so zero in gives zero out at once.
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, 0,          1'b1, 1'b1, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MIN, 1'b1, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, 170,        1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, -171,       1'b0, 1'b0, 0},
    // Writes to unused indexes must leave the reset coefficients in place.
    '{ROW_WRITE,  CFG_IDX_SPARE_LO, 0,        1'b0, 1'b0, 0},
    '{ROW_WRITE,  CFG_IDX_SPARE_HI, COEF_MIN, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MAX, 1'b0, 1'b0, 0},
    // Unity feed-forward gain and no feedback: the output equals the input.
    '{ROW_WRITE,  bqlp_pkg::CFG_COEF_A0, COEF_UNITY, 1'b0, 1'b0, 0},
    '{ROW_WRITE,  bqlp_pkg::CFG_COEF_A1, 0,          1'b0, 1'b0, 0},
    '{ROW_WRITE,  bqlp_pkg::CFG_COEF_A2, 0,          1'b0, 1'b0, 0},
    '{ROW_WRITE,  bqlp_pkg::CFG_COEF_B1, 0,          1'b0, 1'b0, 0},
    '{ROW_WRITE,  bqlp_pkg::CFG_COEF_B2, 0,          1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MAX},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MIN, 1'b0, 1'b1, SAMPLE_MIN},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, 1,          1'b0, 1'b1, 1},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, -1,         1'b0, 1'b1, -1},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, 0,          1'b0, 1'b1, 0},
    // Extreme gains with strong positive feedback: the output history grows
    // fast, so the emitted value saturates and the history wraps.
    '{ROW_WRITE,  bqlp_pkg::CFG_COEF_A0, COEF_MAX, 1'b0, 1'b0, 0},
    '{ROW_WRITE,  bqlp_pkg::CFG_COEF_A1, COEF_MAX, 1'b0, 1'b0, 0},
    '{ROW_WRITE,  bqlp_pkg::CFG_COEF_A2, COEF_MAX, 1'b0, 1'b0, 0},
    '{ROW_WRITE,  bqlp_pkg::CFG_COEF_B1, COEF_MIN, 1'b0, 1'b0, 0},
    '{ROW_WRITE,  bqlp_pkg::CFG_COEF_B2, COEF_MIN, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MAX, 1'b1, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MAX, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MAX, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MAX, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MAX, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MIN, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MIN, 1'b0, 1'b0, 0},
    '{ROW_SAMPLE, bqlp_pkg::CFG_COEF_A0, SAMPLE_MIN, 1'b0, 1'b0, 0}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [bqlp_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [bqlp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  bqlp_in_if  in_if ();
  bqlp_out_if out_if ();

  biquad_lowpass_filter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Model state: the coefficients as written, the two previous scaled inputs
  // and the two previous outputs at the filter's own widths.
  logic signed [bqlp_pkg::COEF_W-1:0] coef_q [5];
  logic signed [bqlp_pkg::XH_W-1:0]   xhist_q [2];
  logic signed [bqlp_pkg::YH_W-1:0]   yhist_q [2];

  // Filtered samples still owed by the filter, oldest first.
  logic signed [bqlp_pkg::OUT_W-1:0]  pending_outputs [$];

  int error_count;
  int burst_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the filter hangs; a correct run ends far earlier.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Advances the model by one sample and returns the emitted value. The sum
  // is formed exactly in 64 bits, both divisions truncate toward zero, and
  // the new output history keeps only its low 32 bits.
  function automatic logic signed [bqlp_pkg::OUT_W-1:0] biquad_next(
    input logic signed [bqlp_pkg::SAMPLE_W-1:0] sample,
    input logic                                 clear
  );
    logic signed [bqlp_pkg::XH_W-1:0] x0;
    longint                           acc;
    longint                           quo;
    int                               y0;
    int                               scaled;
    if (clear) begin
      xhist_q[0] = '0;
      xhist_q[1] = '0;
      yhist_q[0] = '0;
      yhist_q[1] = '0;
    end
    x0  = bqlp_pkg::XH_W'(longint'(sample) <<< bqlp_pkg::IN_SCALE_SHIFT);
    acc = longint'(coef_q[0]) * longint'(x0)
        + longint'(coef_q[1]) * longint'(xhist_q[0])
        + longint'(coef_q[2]) * longint'(xhist_q[1])
        - (longint'(coef_q[3]) * longint'(yhist_q[0])
         + longint'(coef_q[4]) * longint'(yhist_q[1]));
    quo = acc / (longint'(1) << bqlp_pkg::COEF_FRAC_BITS);
    y0  = int'(quo);
    xhist_q[1] = xhist_q[0];
    xhist_q[0] = x0;
    yhist_q[1] = yhist_q[0];
    yhist_q[0] = y0;
    scaled = y0 / (1 << bqlp_pkg::OUT_SCALE_SHIFT);
    if (scaled > OUT_MAX) begin
      scaled = OUT_MAX;
    end else if (scaled < OUT_MIN) begin
      scaled = OUT_MIN;
    end
    return bqlp_pkg::OUT_W'(scaled);
  endfunction

  // Raises the write enable and waits for a clock edge. The caller lowers it once the
  // series of writes is done, so it is never lowered and raised in one step.
  task automatic write_coef(input logic [bqlp_pkg::CFG_IDX_W-1:0] idx, input int data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= bqlp_pkg::CFG_DATA_W'(data);
    @(posedge clk_i);
    if (idx <= bqlp_pkg::CFG_COEF_B2) begin
      coef_q[idx] = bqlp_pkg::COEF_W'(data);
    end
  endtask

  // Stops sending and waits until every owed result has arrived. Every sample
  // yields exactly one result, so the filter is idle at that point.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_outputs.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Sends one sample and records the result it must produce. Between bursts
  // the valid line drops for a random gap.
  task automatic push_sample(
    input logic signed [bqlp_pkg::SAMPLE_W-1:0] sample,
    input logic                                 clear,
    input logic                                 known,
    input logic signed [bqlp_pkg::OUT_W-1:0]    result
  );
    logic signed [bqlp_pkg::OUT_W-1:0] predicted;
    cfg_we_i <= 1'b0;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(300, 100)
                                               : $urandom_range(16, 1);
    end
    in_if.valid         <= 1'b1;
    in_if.sample        <= sample;
    in_if.clear_history <= clear;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
    burst_left--;
    predicted = biquad_next(sample, clear);
    pending_outputs.push_back(known ? result : predicted);
  endtask

  // Result side: checks each transfer against the oldest owed result, then
  // picks the ready level for the next cycle from the current stall pattern.
  initial begin : result_sink
    stall_e                            stall_mode;
    int                                mode_left;
    int                                cycle_cnt;
    logic signed [bqlp_pkg::OUT_W-1:0] owed;
    out_if.ready <= 1'b0;
    stall_mode = STALL_NONE;
    mode_left  = 0;
    cycle_cnt  = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (pending_outputs.size() == 0) begin
          $error("filtered_sample: expected none, actual %0d", out_if.filtered_sample);
          error_count++;
        end else begin
          owed = pending_outputs.pop_front();
          if (out_if.filtered_sample !== owed) begin
            $error("filtered_sample: expected %0d, actual %0d", owed,
                   out_if.filtered_sample);
            error_count++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = stall_e'($urandom_range(STALL_HEAVY, STALL_NONE));
        mode_left  = $urandom_range(200, 16);
      end
      mode_left--;
      cycle_cnt++;
      case (stall_mode)
        STALL_NONE:     out_if.ready <= 1'b1;
        STALL_COIN:     out_if.ready <= 1'($urandom_range(1, 0));
        STALL_PERIODIC: out_if.ready <= (cycle_cnt % 4 != 0);
        default:        out_if.ready <= ($urandom_range(4, 0) == 0);
      endcase
    end
  end

  initial begin : stimulus
    coef_set_e                            coef_set;
    int                                   data;
    int                                   pick;
    logic signed [bqlp_pkg::SAMPLE_W-1:0] sample;
    logic                                 clear;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= bqlp_pkg::CFG_COEF_A0;
    cfg_data_i          <= '0;
    in_if.valid         <= 1'b0;
    in_if.sample        <= '0;
    in_if.clear_history <= 1'b0;
    error_count = 0;
    burst_left  = 0;
    for (int k = 0; k <= bqlp_pkg::CFG_COEF_B2; k++) begin
      coef_q[k] = RESET_COEFS[k];
    end
    for (int k = 0; k < 2; k++) begin
      xhist_q[k] = '0;
      yhist_q[k] = '0;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Register rows wait for the filter to drain first.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        wait_idle();
        write_coef(directed_rows[r].reg_idx, directed_rows[r].value);
      end else begin
        push_sample(bqlp_pkg::SAMPLE_W'(directed_rows[r].value), directed_rows[r].clear,
                    directed_rows[r].known, bqlp_pkg::OUT_W'(directed_rows[r].result));
      end
    end

    // Random phases. The first two pin the all-maximum and all-minimum sets
    // so both extremes are always covered.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_idle();
      if (phase == 0) begin
        coef_set = SET_MAX;
      end else if (phase == 1) begin
        coef_set = SET_MIN;
      end else begin
        coef_set = coef_set_e'($urandom_range(SET_FIR, SET_RESET));
      end
      for (int k = 0; k <= bqlp_pkg::CFG_COEF_B2; k++) begin
        case (coef_set)
          SET_RESET:   data = RESET_COEFS[k];
          SET_MAX:     data = COEF_MAX;
          SET_MIN:     data = COEF_MIN;
          SET_MIXED: begin
            pick = $urandom_range(2, 0);
            data = (pick == 0) ? COEF_MAX : (pick == 1) ? COEF_MIN : 0;
          end
          SET_RANDOM:  data = $urandom_range(2**bqlp_pkg::COEF_W - 1, 0);
          // A slight detuning keeps the poles inside the unit circle.
          SET_DETUNED: data = int'(RESET_COEFS[k]) + int'($urandom_range(128, 0)) - 64;
          default:     data = (k <= bqlp_pkg::CFG_COEF_A2)
                              ? int'($urandom_range(2**bqlp_pkg::COEF_W - 1, 0)) : 0;
        endcase
        write_coef(bqlp_pkg::CFG_IDX_W'(k), data);
      end
      // A stray write to an unused index must not disturb the set just loaded.
      if ($urandom_range(1, 0) == 1) begin
        write_coef(bqlp_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_HI, CFG_IDX_SPARE_LO)),
                   $urandom_range(2**bqlp_pkg::CFG_DATA_W - 1, 0));
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99, 0);
        if (pick < 10) begin
          sample = ($urandom_range(1, 0) == 1) ? bqlp_pkg::SAMPLE_W'(SAMPLE_MAX)
                                              : bqlp_pkg::SAMPLE_W'(SAMPLE_MIN);
        end else if (pick < 40) begin
          sample = bqlp_pkg::SAMPLE_W'(int'($urandom_range(16, 0)) - 8);
        end else begin
          sample = bqlp_pkg::SAMPLE_W'($urandom_range(2**bqlp_pkg::SAMPLE_W - 1, 0));
        end
        clear = ($urandom_range(31, 0) == 0);
        push_sample(sample, clear, 1'b0, '0);
      end
    end

    // Drain, then give any stray extra result time to show up.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
